// ===== design/ico_pkg.sv =====
// Package: shared types and constants of the icosphere triangle subdivider.
package ico_pkg;

   localparam logic [1:0] ACT_LOAD   = 2'd0;
   localparam logic [1:0] ACT_SUBDIV = 2'd1;
   localparam logic [1:0] ACT_LEVEL  = 2'd2;
   localparam logic [1:0] ACT_NONE   = 2'd3;

   localparam logic [1:0] KIND_VERTEX = 2'd0;
   localparam logic [1:0] KIND_TRI    = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam int COORD_W = 16;
   localparam int REF_W   = 8;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic [7:0]         a;
      logic [7:0]         b;
      logic [7:0]         c;
   } cmd_type;

endpackage

// ===== design/ico_front.sv =====
// Front end: accepts items, drops unused codes and queues work for the back end.
module ico_front
   import ico_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_start,
   input  cmd_type req_cmd,
   output logic    req_busy,
   output logic    q_valid,
   output cmd_type q_cmd,
   input  logic    q_pop
);

   logic    full_ff, full_in;
   logic    has_ff, has_in;
   cmd_type slot_ff, slot_in;
   logic    push;

   // one-entry queue; busy while occupied so a single item is in flight
   assign req_busy = has_ff;
   assign push     = req_start && !has_ff && (req_cmd.action != ACT_NONE);
   assign q_valid  = full_ff;
   assign q_cmd    = slot_ff;

   always_comb begin
      full_in = full_ff;
      has_in  = has_ff;
      slot_in = slot_ff;
      if (push) begin
         full_in = 1'b1;
         has_in  = 1'b1;
         slot_in = req_cmd;
      end
      if (q_pop) begin
         full_in = 1'b0;
         has_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
         has_ff  <= 1'b0;
      end else begin
         full_ff <= full_in;
         has_ff  <= has_in;
      end
      slot_ff <= slot_in;
   end

endmodule

// ===== design/ico_back.sv =====
// Back end: vertex store, edge cache search, normalisation and record output.
module ico_back
   import ico_pkg::*;
#(
   parameter int VERTEX_DEPTH = 256,
   parameter int EDGE_DEPTH   = 512,
   parameter int FRAC_BITS    = 14
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  cmd_type            q_cmd,
   output logic               q_pop,
   output logic               rsp_valid,
   output logic [1:0]         rsp_record_kind,
   output logic [7:0]         rsp_first_ref,
   output logic [7:0]         rsp_second_ref,
   output logic [7:0]         rsp_third_ref,
   output logic signed [15:0] rsp_out_x,
   output logic signed [15:0] rsp_out_y,
   output logic signed [15:0] rsp_out_z,
   output logic               rsp_last
);

   localparam int VAW = $clog2(VERTEX_DEPTH);
   localparam int VCW = $clog2(VERTEX_DEPTH + 1);
   localparam int EAW = $clog2(EDGE_DEPTH);
   localparam int ECW = $clog2(EDGE_DEPTH + 1);
   localparam int SW  = 36;
   localparam int RW  = SW;
   localparam int NW  = 17 + FRAC_BITS + 1;
   localparam logic [NW-1:0] ONE = NW'(1) << FRAC_BITS;

   typedef enum logic [14:0] {
      ST_IDLE  = 15'd1,
      ST_LOAD  = 15'd2,
      ST_EDGE  = 15'd4,
      ST_ERD   = 15'd8,
      ST_ECMP  = 15'd16,
      ST_VRD   = 15'd32,
      ST_VWAIT = 15'd64,
      ST_SQ    = 15'd128,
      ST_SQRT  = 15'd256,
      ST_DIV   = 15'd512,
      ST_DSTEP = 15'd1024,
      ST_STORE = 15'd2048,
      ST_TRI   = 15'd4096,
      ST_ERR   = 15'd8192,
      ST_DONE  = 15'd16384
   } state_type;

   state_type state_ff, state_in;

   logic [3*COORD_W-1:0] vmem [VERTEX_DEPTH];
   logic [15:0]          kmem [EDGE_DEPTH];
   logic [7:0]           mmem [EDGE_DEPTH];

   logic [VCW-1:0] vcount_ff, vcount_in;
   logic [ECW-1:0] ecount_ff, ecount_in;
   logic [VAW-1:0] vra_ff, vra_in;
   logic [EAW-1:0] era_ff, era_in;
   logic [ECW-1:0] scan_ff, scan_in;
   logic [3*COORD_W-1:0] vrd_ff;
   logic [15:0]    krd_ff;
   logic [7:0]     mrd_ff;

   logic [1:0]     edge_ff, edge_in;
   logic [7:0]     lo_ff, lo_in, hi_ff, hi_in;
   logic           rdhi_ff, rdhi_in;
   logic signed [17:0] sum_ff [3];
   logic signed [17:0] sum_in [3];
   logic [7:0]     mid_ff [3];
   logic [7:0]     mid_in [3];
   logic [SW-1:0]  sq_ff, sq_in;
   logic [1:0]     cix_ff, cix_in;
   logic [SW-1:0]  rem_ff, rem_in;
   logic [RW-1:0]  root_ff, root_in;
   logic [SW-1:0]  bit_ff, bit_in;
   logic [NW-1:0]  num_ff, num_in;
   logic [NW-1:0]  quo_ff, quo_in;
   logic [NW-1:0]  drem_ff, drem_in;
   logic [5:0]     dcnt_ff, dcnt_in;
   logic signed [15:0] res_ff [3];
   logic signed [15:0] res_in [3];
   logic [2:0]     tri_ff, tri_in;

   logic           vwe, kwe;
   logic [VAW-1:0] vwa;
   logic [EAW-1:0] kwa;
   logic [3*COORD_W-1:0] vwd;

   logic           o_valid_ff, o_valid_in;
   logic [1:0]     o_kind_ff, o_kind_in;
   logic [7:0]     o_r1_ff, o_r1_in, o_r2_ff, o_r2_in, o_r3_ff, o_r3_in;
   logic signed [15:0] o_x_ff, o_x_in, o_y_ff, o_y_in, o_z_ff, o_z_in;
   logic           o_last_ff, o_last_in;

   logic [16:0]    absv;
   logic [33:0]    asq;
   logic [SW-1:0]  trial;
   logic [NW-1:0]  dtrial;
   logic [NW-1:0]  q_sat;
   logic signed [17:0] comp;
   logic [7:0]     ea, eb;
   logic [15:0]    key;

   assign rsp_valid       = o_valid_ff;
   assign rsp_record_kind = o_kind_ff;
   assign rsp_first_ref   = o_r1_ff;
   assign rsp_second_ref  = o_r2_ff;
   assign rsp_third_ref   = o_r3_ff;
   assign rsp_out_x       = o_x_ff;
   assign rsp_out_y       = o_y_ff;
   assign rsp_out_z       = o_z_ff;
   assign rsp_last        = o_last_ff;

   always_ff @(posedge clock) begin
      if (vwe) vmem[vwa] <= vwd;
      if (kwe) begin
         kmem[kwa] <= key;
         mmem[kwa] <= 8'(vwa);
      end
      vrd_ff <= vmem[vra_ff];
      krd_ff <= kmem[era_ff];
      mrd_ff <= mmem[era_ff];
   end

   always_comb begin
      case (edge_ff)
         2'd0:    begin ea = q_cmd.a; eb = q_cmd.b; end
         2'd1:    begin ea = q_cmd.b; eb = q_cmd.c; end
         default: begin ea = q_cmd.c; eb = q_cmd.a; end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      vcount_in = vcount_ff;
      ecount_in = ecount_ff;
      vra_in    = vra_ff;
      era_in    = era_ff;
      scan_in   = scan_ff;
      edge_in   = edge_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      rdhi_in   = rdhi_ff;
      sum_in    = sum_ff;
      mid_in    = mid_ff;
      sq_in     = sq_ff;
      cix_in    = cix_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      bit_in    = bit_ff;
      num_in    = num_ff;
      quo_in    = quo_ff;
      drem_in   = drem_ff;
      dcnt_in   = dcnt_ff;
      res_in    = res_ff;
      tri_in    = tri_ff;
      q_pop     = 1'b0;
      vwe       = 1'b0;
      kwe       = 1'b0;
      vwa       = vcount_ff[VAW-1:0];
      kwa       = ecount_ff[EAW-1:0];
      vwd       = {res_ff[0], res_ff[1], res_ff[2]};
      key       = {lo_ff, hi_ff};
      o_valid_in = 1'b0;
      o_kind_in  = KIND_VERTEX;
      o_r1_in    = '0;
      o_r2_in    = '0;
      o_r3_in    = '0;
      o_x_in     = '0;
      o_y_in     = '0;
      o_z_in     = '0;
      o_last_in  = 1'b0;
      comp  = sum_ff[cix_ff];
      absv  = comp[17] ? 17'(-comp) : comp[16:0];
      asq   = absv * absv;
      trial = rem_ff;
      dtrial = '0;
      q_sat  = '0;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               case (q_cmd.action)
                  ACT_LOAD: begin
                     if (vcount_ff >= VCW'(VERTEX_DEPTH)) begin
                        state_in = ST_ERR;
                     end else begin
                        sum_in[0] = 18'(q_cmd.x);
                        sum_in[1] = 18'(q_cmd.y);
                        sum_in[2] = 18'(q_cmd.z);
                        edge_in   = 2'd3;
                        sq_in     = '0;
                        cix_in    = '0;
                        state_in  = ST_SQ;
                     end
                  end
                  ACT_SUBDIV: begin
                     edge_in  = 2'd0;
                     state_in = ST_EDGE;
                  end
                  default: begin
                     ecount_in = '0;
                     state_in  = ST_DONE;
                  end
               endcase
            end
         end
         ST_EDGE: begin
            lo_in   = (ea < eb) ? ea : eb;
            hi_in   = (ea < eb) ? eb : ea;
            scan_in = '0;
            era_in  = '0;
            state_in = ST_ERD;
         end
         ST_ERD: begin
            if (scan_ff >= ecount_ff) begin
               if (vcount_ff >= VCW'(VERTEX_DEPTH)) begin
                  state_in = ST_ERR;
               end else begin
                  rdhi_in  = 1'b0;
                  vra_in   = VAW'(lo_ff);
                  state_in = ST_VRD;
               end
            end else begin
               state_in = ST_ECMP;
            end
         end
         ST_ECMP: begin
            if (krd_ff == key) begin
               mid_in[edge_ff] = mrd_ff;
               if (edge_ff == 2'd2) begin
                  tri_in   = '0;
                  state_in = ST_TRI;
               end else begin
                  edge_in  = edge_ff + 2'd1;
                  state_in = ST_EDGE;
               end
            end else begin
               scan_in  = scan_ff + ECW'(1);
               era_in   = EAW'(scan_ff + ECW'(1));
               state_in = ST_ERD;
            end
         end
         ST_VRD: begin
            state_in = ST_VWAIT;
         end
         ST_VWAIT: begin
            if (32'(rdhi_ff ? hi_ff : lo_ff) < 32'(vcount_ff)) begin
               if (!rdhi_ff) begin
                  sum_in[0] = 18'($signed(vrd_ff[47:32]));
                  sum_in[1] = 18'($signed(vrd_ff[31:16]));
                  sum_in[2] = 18'($signed(vrd_ff[15:0]));
               end else begin
                  sum_in[0] = sum_ff[0] + 18'($signed(vrd_ff[47:32]));
                  sum_in[1] = sum_ff[1] + 18'($signed(vrd_ff[31:16]));
                  sum_in[2] = sum_ff[2] + 18'($signed(vrd_ff[15:0]));
               end
            end else if (!rdhi_ff) begin
               sum_in[0] = '0;
               sum_in[1] = '0;
               sum_in[2] = '0;
            end
            if (!rdhi_ff) begin
               rdhi_in  = 1'b1;
               vra_in   = VAW'(hi_ff);
               state_in = ST_VRD;
            end else begin
               sq_in    = '0;
               cix_in   = '0;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            sq_in = sq_ff + SW'(asq);
            if (cix_ff == 2'd2) begin
               rem_in  = sq_ff + SW'(asq);
               root_in = '0;
               bit_in  = SW'(1) << (SW - 2);
               state_in = ST_SQRT;
            end else begin
               cix_in = cix_ff + 2'd1;
            end
         end
         ST_SQRT: begin
            if (sq_ff == '0) begin
               res_in[0] = '0;
               res_in[1] = '0;
               res_in[2] = '0;
               state_in  = ST_STORE;
            end else if (bit_ff == '0) begin
               cix_in   = '0;
               state_in = ST_DIV;
            end else begin
               trial = SW'(root_ff) + bit_ff;
               if (rem_ff >= trial) begin
                  rem_in  = rem_ff - trial;
                  root_in = RW'((SW'(root_ff) >> 1) + bit_ff);
               end else begin
                  root_in = root_ff >> 1;
               end
               bit_in = bit_ff >> 2;
            end
         end
         ST_DIV: begin
            num_in  = (NW'(absv) << FRAC_BITS) + NW'(root_ff >> 1);
            quo_in  = '0;
            drem_in = '0;
            dcnt_in = 6'(NW);
            state_in = ST_DSTEP;
         end
         ST_DSTEP: begin
            if (dcnt_ff == '0) begin
               q_sat = (quo_ff > ONE) ? ONE : quo_ff;
               if (comp[17]) res_in[cix_ff] = (q_sat > NW'(32768)) ? -16'sd32768
                                             : 16'(-q_sat);
               else res_in[cix_ff] = (q_sat > NW'(32767)) ? 16'sd32767 : 16'(q_sat);
               if (cix_ff == 2'd2) begin
                  state_in = ST_STORE;
               end else begin
                  cix_in   = cix_ff + 2'd1;
                  state_in = ST_DIV;
               end
            end else begin
               dtrial = {drem_ff[NW-2:0], num_ff[NW-1]};
               num_in = num_ff << 1;
               if (dtrial >= NW'(root_ff)) begin
                  drem_in = dtrial - NW'(root_ff);
                  quo_in  = {quo_ff[NW-2:0], 1'b1};
               end else begin
                  drem_in = dtrial;
                  quo_in  = {quo_ff[NW-2:0], 1'b0};
               end
               dcnt_in = dcnt_ff - 6'd1;
            end
         end
         ST_STORE: begin
            vwe        = 1'b1;
            vwd        = {res_ff[0], res_ff[1], res_ff[2]};
            vcount_in  = vcount_ff + VCW'(1);
            o_valid_in = 1'b1;
            o_kind_in  = KIND_VERTEX;
            o_r1_in    = 8'(vcount_ff);
            o_x_in     = res_ff[0];
            o_y_in     = res_ff[1];
            o_z_in     = res_ff[2];
            if (edge_ff == 2'd3) begin
               o_last_in = 1'b1;
               q_pop     = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               mid_in[edge_ff] = 8'(vcount_ff);
               if (ecount_ff < ECW'(EDGE_DEPTH)) begin
                  kwe       = 1'b1;
                  ecount_in = ecount_ff + ECW'(1);
               end
               if (edge_ff == 2'd2) begin
                  tri_in   = '0;
                  state_in = ST_TRI;
               end else begin
                  edge_in  = edge_ff + 2'd1;
                  state_in = ST_EDGE;
               end
            end
         end
         ST_TRI: begin
            o_valid_in = 1'b1;
            o_kind_in  = KIND_TRI;
            case (tri_ff)
               3'd0: begin o_r1_in = q_cmd.a; o_r2_in = mid_ff[0]; o_r3_in = mid_ff[2]; end
               3'd1: begin o_r1_in = q_cmd.b; o_r2_in = mid_ff[1]; o_r3_in = mid_ff[0]; end
               3'd2: begin o_r1_in = q_cmd.c; o_r2_in = mid_ff[2]; o_r3_in = mid_ff[1]; end
               default: begin
                  o_r1_in = mid_ff[0]; o_r2_in = mid_ff[1]; o_r3_in = mid_ff[2];
               end
            endcase
            tri_in = tri_ff + 3'd1;
            if (tri_ff == 3'd3) begin
               o_last_in = 1'b1;
               q_pop     = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_ERR: begin
            o_valid_in = 1'b1;
            o_kind_in  = KIND_ERROR;
            o_last_in  = 1'b1;
            q_pop      = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_DONE: begin
            q_pop    = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         vcount_ff  <= '0;
         ecount_ff  <= '0;
         o_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         vcount_ff  <= vcount_in;
         ecount_ff  <= ecount_in;
         o_valid_ff <= o_valid_in;
      end
      vra_ff  <= vra_in;
      era_ff  <= era_in;
      scan_ff <= scan_in;
      edge_ff <= edge_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      rdhi_ff <= rdhi_in;
      sum_ff  <= sum_in;
      mid_ff  <= mid_in;
      sq_ff   <= sq_in;
      cix_ff  <= cix_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      num_ff  <= num_in;
      quo_ff  <= quo_in;
      drem_ff <= drem_in;
      dcnt_ff <= dcnt_in;
      res_ff  <= res_in;
      tri_ff  <= tri_in;
      o_kind_ff <= o_kind_in;
      o_r1_ff   <= o_r1_in;
      o_r2_ff   <= o_r2_in;
      o_r3_ff   <= o_r3_in;
      o_x_ff    <= o_x_in;
      o_y_ff    <= o_y_in;
      o_z_ff    <= o_z_in;
      o_last_ff <= o_last_in;
   end

endmodule

// ===== design/icosphere_triangle_subdivider.sv =====
// Top level of the icosphere triangle subdivider.
//
//   channel   ports      handshake
//   input     req_*      accepted when start is high and busy is low
//   output    rsp_*      records marked by rsp_valid
//
// A load squares each coordinate, takes a bitwise square root and runs three
// restoring divisions before its record shows. A subdivide compares the cached
// edges one by one, computes each new midpoint, then emits four triangle
// records. Busy drops as the last record shows; the next item may be
// accepted at the edge that ends it.
// Reset is synchronous; stores need no clearing. Results cannot be stalled.
module icosphere_triangle_subdivider
   import ico_pkg::*;
#(
   parameter int VERTEX_DEPTH = 256,
   parameter int EDGE_DEPTH   = 512,
   parameter int FRAC_BITS    = 14
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_action,
   input  logic signed [15:0] req_coord_x,
   input  logic signed [15:0] req_coord_y,
   input  logic signed [15:0] req_coord_z,
   input  logic [7:0]         req_index_a,
   input  logic [7:0]         req_index_b,
   input  logic [7:0]         req_index_c,
   output logic               rsp_valid,
   output logic [1:0]         rsp_record_kind,
   output logic [7:0]         rsp_first_ref,
   output logic [7:0]         rsp_second_ref,
   output logic [7:0]         rsp_third_ref,
   output logic signed [15:0] rsp_out_x,
   output logic signed [15:0] rsp_out_y,
   output logic signed [15:0] rsp_out_z,
   output logic               rsp_last
);

   cmd_type req_cmd, q_cmd;
   logic    q_valid, q_pop;

   assign req_cmd = '{action: req_action, x: req_coord_x, y: req_coord_y,
                      z: req_coord_z, a: req_index_a, b: req_index_b,
                      c: req_index_c};

   ico_front u_front (
      .clock(clock), .reset(reset), .req_start(start), .req_cmd(req_cmd),
      .req_busy(busy), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
   );

   ico_back #(
      .VERTEX_DEPTH(VERTEX_DEPTH), .EDGE_DEPTH(EDGE_DEPTH), .FRAC_BITS(FRAC_BITS)
   ) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_cmd(q_cmd),
      .q_pop(q_pop), .rsp_valid(rsp_valid), .rsp_record_kind(rsp_record_kind),
      .rsp_first_ref(rsp_first_ref), .rsp_second_ref(rsp_second_ref),
      .rsp_third_ref(rsp_third_ref), .rsp_out_x(rsp_out_x),
      .rsp_out_y(rsp_out_y), .rsp_out_z(rsp_out_z), .rsp_last(rsp_last)
   );

endmodule

// ===== design/ico_checker.sv =====
// Port checker for the icosphere triangle subdivider, bound to the top level.
module ico_checker
   import ico_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [1:0] rsp_record_kind,
   input logic [7:0] rsp_second_ref,
   input logic       rsp_last
);

   a_no_out_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> busy) else $error("record while idle");

   a_kind_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_record_kind <= KIND_ERROR)) else $error("bad record kind");

   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_record_kind == KIND_ERROR) |-> rsp_last)
      else $error("error record not last");

   a_free_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy) else $error("busy after last");

   a_vertex_refs: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_record_kind == KIND_VERTEX) |-> rsp_second_ref == 8'd0)
      else $error("vertex record with corner");

endmodule

bind icosphere_triangle_subdivider ico_checker u_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_record_kind(rsp_record_kind),
   .rsp_second_ref(rsp_second_ref), .rsp_last(rsp_last)
);
